// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared control types for the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Input operation codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Per-cycle control that the top level hands to every cell.
  typedef struct packed {
    logic ins;         // insert beat accepted and the queue is not full
    logic rm;          // remove beat accepted and the queue is not empty
    logic occ;         // this cell holds a stored entry
    logic place_left;  // left neighbor is at or past the insert point
  } cell_ctrl_t;

endpackage

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue
// Row of DEPTH cells kept in ascending key order; one insert or remove per
// beat, each beat answered by one result beat.
// ----------------------------------------------------------------------------
//  Channel | Ports                                          | Direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_func, in_new_key,       | input
//          | in_new_payload                                 |
//  out     | out_valid, out_ready, out_removed_*, out_head_*| output
//          | out_entry_count, out_insert_dropped            |
//
// Every cell compares the new key in parallel and shifts in the same cycle,
// so an accepted beat is finished at the edge that takes it and its result sits in the
// output register. A new beat is taken every cycle as long as the output
// register is empty or being drained. Reset clears only the internal count and
// the output valid; cells and result registers are don't-care until written. A stalled
// output holds its result and stops input acceptance.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH        = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16,
  localparam int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [KEY_BITS-1:0]     in_new_key,
  input  logic [PAYLOAD_BITS-1:0] in_new_payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_removed_valid,
  output logic [KEY_BITS-1:0]     out_removed_key,
  output logic [PAYLOAD_BITS-1:0] out_removed_payload,
  output logic                    out_head_valid,
  output logic [KEY_BITS-1:0]     out_head_key,
  output logic [PAYLOAD_BITS-1:0] out_head_payload,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_insert_dropped
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    rm_valid_r;
  logic                    rm_valid_nxt;
  logic [KEY_BITS-1:0]     rm_key_r;
  logic [KEY_BITS-1:0]     rm_key_nxt;
  logic [PAYLOAD_BITS-1:0] rm_pay_r;
  logic [PAYLOAD_BITS-1:0] rm_pay_nxt;
  logic                    head_valid_r;
  logic                    head_valid_nxt;
  logic [KEY_BITS-1:0]     head_key_r;
  logic [KEY_BITS-1:0]     head_key_nxt;
  logic [PAYLOAD_BITS-1:0] head_pay_r;
  logic [PAYLOAD_BITS-1:0] head_pay_nxt;
  logic                    dropped_r;
  logic                    dropped_nxt;
  logic [CNT_W-1:0]        entry_count_r;

  logic                    accept;
  logic                    is_insert;
  logic                    full;
  logic                    empty;
  logic                    do_ins;
  logic                    do_rm;

  logic [DEPTH-1:0]        place;
  logic [KEY_BITS-1:0]     cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = (in_func == spq_pkg::FUNC_INSERT);
  assign full      = (count_r == FULL_COUNT);
  assign empty     = (count_r == '0);
  assign do_ins    = accept && is_insert && !full;
  assign do_rm     = accept && !is_insert && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_ctrl_t     ctrl;
    logic [KEY_BITS-1:0]     left_key;
    logic [PAYLOAD_BITS-1:0] left_pay;
    logic [KEY_BITS-1:0]     right_key;
    logic [PAYLOAD_BITS-1:0] right_pay;

    assign ctrl.ins = do_ins;
    assign ctrl.rm  = do_rm;
    assign ctrl.occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign ctrl.place_left = 1'b0;
      assign left_key        = '0;
      assign left_pay        = '0;
    end else begin : g_mid
      assign ctrl.place_left = place[i-1];
      assign left_key        = cell_key[i-1];
      assign left_pay        = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = '0;
      assign right_pay = '0;
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_pay = cell_pay[i+1];
    end

    spq_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_key       (in_new_key),
      .new_payload   (in_new_payload),
      .left_key      (left_key),
      .left_payload  (left_pay),
      .right_key     (right_key),
      .right_payload (right_pay),
      .place         (place[i]),
      .key           (cell_key[i]),
      .payload       (cell_pay[i])
    );
  end

  // The result shows the front after the step, so it is taken from what the
  // front cell is about to load rather than what it holds now.
  always_comb begin
    count_nxt      = count_r;
    rm_valid_nxt   = 1'b0;
    rm_key_nxt     = '0;
    rm_pay_nxt     = '0;
    head_valid_nxt = !empty;
    head_key_nxt   = empty ? '0 : cell_key[0];
    head_pay_nxt   = empty ? '0 : cell_pay[0];
    dropped_nxt    = accept && is_insert && full;
    if (do_ins) begin
      count_nxt      = count_r + 1'b1;
      head_valid_nxt = 1'b1;
      if (place[0]) begin
        head_key_nxt = in_new_key;
        head_pay_nxt = in_new_payload;
      end
    end else if (do_rm) begin
      count_nxt    = count_r - 1'b1;
      rm_valid_nxt = 1'b1;
      rm_key_nxt   = cell_key[0];
      rm_pay_nxt   = cell_pay[0];
      if (count_r > CNT_W'(1)) begin
        head_valid_nxt = 1'b1;
        head_key_nxt   = cell_key[1];
        head_pay_nxt   = cell_pay[1];
      end else begin
        head_valid_nxt = 1'b0;
        head_key_nxt   = '0;
        head_pay_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rm_valid_r    <= rm_valid_nxt;
      rm_key_r      <= rm_key_nxt;
      rm_pay_r      <= rm_pay_nxt;
      head_valid_r  <= head_valid_nxt;
      head_key_r    <= head_key_nxt;
      head_pay_r    <= head_pay_nxt;
      dropped_r     <= dropped_nxt;
      entry_count_r <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_removed_valid   = rm_valid_r;
  assign out_removed_key     = rm_key_r;
  assign out_removed_payload = rm_pay_r;
  assign out_head_valid      = head_valid_r;
  assign out_head_key        = head_key_r;
  assign out_head_payload    = head_pay_r;
  assign out_entry_count     = entry_count_r;
  assign out_insert_dropped  = dropped_r;

endmodule

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it against the incoming key and shifts toward
// its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  spq_pkg::cell_ctrl_t     ctrl,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic                    place,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload
);

  logic [KEY_BITS-1:0]     key_r;
  logic [KEY_BITS-1:0]     key_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [PAYLOAD_BITS-1:0] payload_nxt;

  // An empty cell, or one whose key is not below the new key, lies at or past
  // the insert point. Along a sorted row this flag rises once and stays high.
  assign place = !ctrl.occ || (new_key <= key_r);

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctrl.ins) begin
      if (ctrl.place_left) begin
        key_nxt     = left_key;
        payload_nxt = left_payload;
      end else if (place) begin
        key_nxt     = new_key;
        payload_nxt = new_payload;
      end
    end else if (ctrl.rm) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key     = key_r;
  assign payload = payload_r;

endmodule
